[rtl/afbd_pkg.sv]
// shared types, constants and table function for the anchor-free box decode unit
package afbd_pkg;

  // fixed point constants
  localparam logic signed [17:0] LOG2E_Q16     = 18'sd94548;
  localparam logic [63:0]        LN2_Q30       = 64'd744261118;
  localparam logic [16:0]        SIZE_MAX_Q4   = 17'd131071;
  localparam logic signed [23:0] CORNER_MAX    = 24'sd131071;
  localparam logic signed [23:0] CORNER_MIN    = -24'sd131072;
  localparam logic signed [28:0] CENTER_ROUND  = 29'sd32;
  localparam int unsigned        CENTER_SHIFT  = 6;
  localparam int unsigned        TAYLOR_TERMS  = 24;

  // register reset values
  localparam logic [15:0] SCORE_THRESHOLD_RESET = 16'd16384;
  localparam logic [7:0]  CLASS_COUNT_RESET     = 8'd1;

  // queue depths
  localparam int unsigned JOB_QUEUE_DEPTH    = 2;
  localparam int unsigned RESULT_QUEUE_DEPTH = 2;

  // configuration register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_SCORE_THRESHOLD = 1'b0,
    REG_CLASS_COUNT     = 1'b1
  } cfg_reg_e;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_TABLE,
    ST_SCALE,
    ST_SIZE,
    ST_CORNER,
    ST_PROB,
    ST_EMIT
  } state_e;

  // one input word
  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] log_width;
    logic signed [15:0] log_height;
    logic [15:0]        objectness;
    logic [7:0]         grid_x;
    logic [7:0]         grid_y;
    logic [7:0]         stride;
    logic [15:0]        class_score;
  } in_word_t;

  // classified word between front and back
  typedef struct packed {
    in_word_t   word;
    logic       first;
    logic [7:0] label;
  } job_t;

  // one result word
  typedef struct packed {
    logic signed [17:0] left;
    logic signed [17:0] top;
    logic [16:0]        box_width;
    logic [16:0]        box_height;
    logic [7:0]         label;
    logic [15:0]        probability;
  } result_t;

  // 2^(k / 2^idx_w) in Q.30 by a truncating Taylor series of exp, elaboration only
  function automatic logic [30:0] pow2_q30(input int unsigned k, input int unsigned idx_w);
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] sum;
    a    = ((64'(k) * LN2_Q30) + (64'd1 << (idx_w - 1))) >> idx_w;
    term = 64'd1 << 30;
    sum  = term;
    for (int i = 1; i <= int'(TAYLOR_TERMS); i++) begin
      term = ((term * a) >> 30) / 64'(i);
      sum  = sum + term;
    end
    return sum[30:0];
  endfunction

endpackage

[rtl/afbd_fifo.sv]
// small register queue with show-ahead read
module afbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/afbd_front.sv]
// front end: takes input words, tracks the class counter and queues tagged jobs
module afbd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  afbd_pkg::in_word_t word_i,
  input  logic [7:0]       class_count_i,
  input  logic             job_pop_i,
  output afbd_pkg::job_t   job_o,
  output logic             job_empty_o
);

  logic [7:0]             class_counter_q, class_counter_d;
  logic [7:0]             count_eff;
  logic [8:0]             counter_inc;
  logic                   accept;
  afbd_pkg::job_t         job_in;
  logic [$bits(afbd_pkg::job_t)-1:0] job_rdata;

  assign accept = push_i && !full_o;

  // a class count of zero behaves as one
  assign count_eff   = (class_count_i == 8'd0) ? 8'd1 : class_count_i;
  assign counter_inc = {1'b0, class_counter_q} + 9'd1;

  always_comb begin
    class_counter_d = class_counter_q;
    if (accept) begin
      class_counter_d = (counter_inc >= {1'b0, count_eff}) ? 8'd0 : counter_inc[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_counter_q <= 8'd0;
    end else begin
      class_counter_q <= class_counter_d;
    end
  end

  // tag the word with its anchor position
  always_comb begin
    job_in.word  = word_i;
    job_in.first = (class_counter_q == 8'd0);
    job_in.label = class_counter_q;
  end

  // queue towards the back end
  afbd_fifo #(
    .WIDTH ($bits(afbd_pkg::job_t)),
    .DEPTH (afbd_pkg::JOB_QUEUE_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (job_in),
    .full_o  (full_o),
    .pop_i   (job_pop_i),
    .rdata_o (job_rdata),
    .empty_o (job_empty_o)
  );

  assign job_o = afbd_pkg::job_t'(job_rdata);

endmodule

[rtl/afbd_back.sv]
// back end: box decode sequencer, probability and threshold test
module afbd_back #(
  parameter int unsigned EXP_TABLE_SIZE = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afbd_pkg::job_t    job_i,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  input  logic [15:0]       threshold_i,
  input  logic              res_full_i,
  output logic              res_push_o,
  output afbd_pkg::result_t res_o
);

  localparam int unsigned IdxW = $clog2(EXP_TABLE_SIZE);

  afbd_pkg::state_e   state_q, state_d;
  logic               dim_q;
  afbd_pkg::job_t     item_q;

  // latched anchor values
  logic signed [17:0] box_left_q, box_top_q;
  logic [16:0]        box_w_q, box_h_q;
  logic [15:0]        obj_q;

  // datapath registers
  logic signed [33:0] logy_q;
  logic signed [28:0] ctr_q;
  logic [30:0]        tab_q;
  logic signed [7:0]  n_q;
  logic signed [22:0] cround_q;
  logic [38:0]        v_q;
  logic [16:0]        size_q;
  logic [31:0]        prod_q;

  // combinational terms
  logic signed [15:0] off_sel, log_sel;
  logic [7:0]         grid_sel;
  logic signed [19:0] pos_sum;
  logic signed [33:0] logy_d;
  logic signed [28:0] ctr_d;
  logic signed [28:0] ctr_rnd;
  logic [IdxW-1:0]    tab_idx;
  logic signed [8:0]  sh9;
  logic [5:0]         sh_amt;
  logic [39:0]        round_sum, shifted;
  logic [16:0]        size_d;
  logic signed [23:0] corner;
  logic signed [17:0] corner_sat;
  logic [32:0]        prob_sum;
  logic [15:0]        prob;
  logic               hit;

  // exp table, 2^(k/size) in Q.30, fixed at elaboration
  logic [30:0] exp_tab [EXP_TABLE_SIZE];
  for (genvar g = 0; g < int'(EXP_TABLE_SIZE); g++) begin : g_tab
    localparam logic [30:0] TAB_ENTRY = afbd_pkg::pow2_q30(g, IdxW);
    assign exp_tab[g] = TAB_ENTRY;
  end

  // per-dimension operand select
  always_comb begin
    off_sel  = dim_q ? item_q.word.offset_y   : item_q.word.offset_x;
    log_sel  = dim_q ? item_q.word.log_height : item_q.word.log_width;
    grid_sel = dim_q ? item_q.word.grid_y     : item_q.word.grid_x;
  end

  // center and log products
  assign pos_sum = $signed({{4{off_sel[15]}}, off_sel}) + $signed({2'b00, grid_sel, 10'd0});
  assign ctr_d   = pos_sum * $signed({1'b0, item_q.word.stride});
  assign logy_d  = log_sel * afbd_pkg::LOG2E_Q16;

  // table index and center rounding
  assign tab_idx = logy_q[25 -: IdxW];
  assign ctr_rnd = (ctr_q + afbd_pkg::CENTER_ROUND) >>> afbd_pkg::CENTER_SHIFT;

  // scale to Q.4 with round half up and saturation
  always_comb begin
    sh9       = 9'sd26 - $signed({n_q[7], n_q});
    sh_amt    = sh9[5:0];
    round_sum = {1'b0, v_q} + (40'd1 << (sh_amt - 6'd1));
    shifted   = round_sum >> sh_amt;
    if (v_q == 39'd0) begin
      size_d = 17'd0;
    end else if (n_q >= 8'sd26) begin
      size_d = afbd_pkg::SIZE_MAX_Q4;
    end else if (n_q < -8'sd14) begin
      size_d = 17'd0;
    end else if (shifted > {23'd0, afbd_pkg::SIZE_MAX_Q4}) begin
      size_d = afbd_pkg::SIZE_MAX_Q4;
    end else begin
      size_d = shifted[16:0];
    end
  end

  // corner with saturation
  always_comb begin
    corner = $signed({cround_q[22], cround_q}) - $signed({8'd0, size_q[16:1]});
    if (corner > afbd_pkg::CORNER_MAX) begin
      corner_sat = 18'sd131071;
    end else if (corner < afbd_pkg::CORNER_MIN) begin
      corner_sat = -18'sd131072;
    end else begin
      corner_sat = corner[17:0];
    end
  end

  // probability rounding and threshold test
  assign prob_sum = {1'b0, prod_q} + 33'd32768;
  assign prob     = prob_sum[31:16];
  assign hit      = (prob > threshold_i);

  // sequencer next state and handshakes
  always_comb begin
    state_d    = state_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      afbd_pkg::ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          state_d   = job_i.first ? afbd_pkg::ST_MULT : afbd_pkg::ST_PROB;
        end
      end
      afbd_pkg::ST_MULT:   state_d = afbd_pkg::ST_TABLE;
      afbd_pkg::ST_TABLE:  state_d = afbd_pkg::ST_SCALE;
      afbd_pkg::ST_SCALE:  state_d = afbd_pkg::ST_SIZE;
      afbd_pkg::ST_SIZE:   state_d = afbd_pkg::ST_CORNER;
      afbd_pkg::ST_CORNER: state_d = dim_q ? afbd_pkg::ST_PROB : afbd_pkg::ST_MULT;
      afbd_pkg::ST_PROB:   state_d = afbd_pkg::ST_EMIT;
      afbd_pkg::ST_EMIT: begin
        if (!hit) begin
          state_d = afbd_pkg::ST_IDLE;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = afbd_pkg::ST_IDLE;
        end
      end
      default: state_d = afbd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afbd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // dimension flag and latched anchor values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q      <= 1'b0;
      box_left_q <= '0;
      box_top_q  <= '0;
      box_w_q    <= '0;
      box_h_q    <= '0;
      obj_q      <= '0;
    end else begin
      if (job_pop_o) begin
        dim_q <= 1'b0;
        if (job_i.first) begin
          obj_q <= job_i.word.objectness;
        end
      end
      if (state_q == afbd_pkg::ST_CORNER) begin
        dim_q <= 1'b1;
        if (dim_q) begin
          box_top_q <= corner_sat;
          box_h_q   <= size_q;
        end else begin
          box_left_q <= corner_sat;
          box_w_q    <= size_q;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      item_q <= job_i;
    end
    if (state_q == afbd_pkg::ST_MULT) begin
      logy_q <= logy_d;
      ctr_q  <= ctr_d;
    end
    if (state_q == afbd_pkg::ST_TABLE) begin
      tab_q    <= exp_tab[tab_idx];
      n_q      <= logy_q[33:26];
      cround_q <= ctr_rnd[22:0];
    end
    if (state_q == afbd_pkg::ST_SCALE) begin
      v_q <= tab_q * item_q.word.stride;
    end
    if (state_q == afbd_pkg::ST_SIZE) begin
      size_q <= size_d;
    end
    if (state_q == afbd_pkg::ST_PROB) begin
      prod_q <= obj_q * item_q.word.class_score;
    end
  end

  // result word
  always_comb begin
    res_o.left        = box_left_q;
    res_o.top         = box_top_q;
    res_o.box_width   = box_w_q;
    res_o.box_height  = box_h_q;
    res_o.label       = item_q.label;
    res_o.probability = prob;
  end

`ifndef SYNTHESIS
  a_pop_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> !job_empty_i && state_q == afbd_pkg::ST_IDLE)
    else $error("job popped outside idle or from an empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_push_above_threshold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> res_o.probability > threshold_i)
    else $error("result pushed at or below threshold");

  a_both_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afbd_pkg::ST_CORNER && !dim_q) |=> (state_q == afbd_pkg::ST_MULT && dim_q))
    else $error("second dimension skipped");

  a_prob_after_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afbd_pkg::ST_PROB) |=> state_q == afbd_pkg::ST_EMIT)
    else $error("probability step not followed by emit");
`endif

endmodule

[rtl/anchor_free_box_decode_unit.sv]
// top level of the anchor-free box decode unit: config registers, front, back, result queue
//
//  channel   direction  handshake                   word
//  input     in         push / full                 anchor features and one class score
//  result    out        pop / empty                 box, label and probability
//  config    in/out     psel, penable, pwrite, pready  threshold (0x0), class count (0x4)
//
// a class score word that is not the first of its anchor goes only through the probability
// and emit steps in the back end; the first word of an anchor also runs the shared multiply,
// table, scale, size and corner steps, once for x and once for y.
// the front queue holds two words, so input is taken while the back end is busy, until it is full.
// a result waits in a two-word queue; emit stalls only while that queue is full.
// reset is asynchronous and active low; no clearing pass, words are taken at once.
module anchor_free_box_decode_unit #(
  parameter int unsigned EXP_TABLE_SIZE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input queue
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic signed [15:0] log_width_i,
  input  logic signed [15:0] log_height_i,
  input  logic [15:0]        objectness_i,
  input  logic [7:0]         grid_x_i,
  input  logic [7:0]         grid_y_i,
  input  logic [7:0]         stride_i,
  input  logic [15:0]        class_score_i,
  // result queue
  output logic               empty,
  input  logic               pop,
  output logic signed [17:0] left_o,
  output logic signed [17:0] top_o,
  output logic [16:0]        box_width_o,
  output logic [16:0]        box_height_o,
  output logic [7:0]         label_o,
  output logic [15:0]        probability_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0]              threshold_q;
  logic [7:0]               class_count_q;
  logic                     cfg_write;
  afbd_pkg::in_word_t       word_in;
  afbd_pkg::job_t           job;
  logic                     job_empty, job_pop;
  logic                     res_full, res_push;
  afbd_pkg::result_t        res_word, res_head;
  logic [$bits(afbd_pkg::result_t)-1:0] res_rdata;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= afbd_pkg::SCORE_THRESHOLD_RESET;
      class_count_q <= afbd_pkg::CLASS_COUNT_RESET;
    end else if (cfg_write) begin
      case (afbd_pkg::cfg_reg_e'(paddr[2]))
        afbd_pkg::REG_SCORE_THRESHOLD: threshold_q   <= pwdata[15:0];
        afbd_pkg::REG_CLASS_COUNT:     class_count_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (afbd_pkg::cfg_reg_e'(paddr[2]))
      afbd_pkg::REG_SCORE_THRESHOLD: prdata = {16'd0, threshold_q};
      afbd_pkg::REG_CLASS_COUNT:     prdata = {24'd0, class_count_q};
      default:                       prdata = 32'd0;
    endcase
  end

  // gather the input word
  always_comb begin
    word_in.offset_x    = offset_x_i;
    word_in.offset_y    = offset_y_i;
    word_in.log_width   = log_width_i;
    word_in.log_height  = log_height_i;
    word_in.objectness  = objectness_i;
    word_in.grid_x      = grid_x_i;
    word_in.grid_y      = grid_y_i;
    word_in.stride      = stride_i;
    word_in.class_score = class_score_i;
  end

  afbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .word_i        (word_in),
    .class_count_i (class_count_q),
    .job_pop_i     (job_pop),
    .job_o         (job),
    .job_empty_o   (job_empty)
  );

  afbd_back #(
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .threshold_i (threshold_q),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_word)
  );

  // result queue
  afbd_fifo #(
    .WIDTH ($bits(afbd_pkg::result_t)),
    .DEPTH (afbd_pkg::RESULT_QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_head      = afbd_pkg::result_t'(res_rdata);
  assign left_o        = res_head.left;
  assign top_o         = res_head.top;
  assign box_width_o   = res_head.box_width;
  assign box_height_o  = res_head.box_height;
  assign label_o       = res_head.label;
  assign probability_o = res_head.probability;

endmodule

[sim/anchor_free_box_decode_unit_tb.sv]
// self-checking testbench for the anchor-free box decode unit
`timescale 1ns / 1ps

module anchor_free_box_decode_unit_tb;

  localparam int unsigned     LUT_SIZE      = 256;
  localparam int unsigned     LUT_BITS      = 8;
  localparam longint          LOG2E_FIX     = 94548;
  localparam longint unsigned LN2_FIX       = 744261118;
  localparam longint          SIZE_SAT      = 131071;
  localparam longint          CORNER_HI     = 131071;
  localparam longint          CORNER_LO     = -131072;
  localparam int unsigned     HOLD_CYCLES   = 300;
  localparam int unsigned     SETTLE_CYCLES = 64;
  localparam int unsigned     CYCLE_LIMIT   = 200000;

  // one row of the directed script, with an optional hand-written expectation
  typedef struct {
    afbd_pkg::in_word_t word;
    bit                 fixed;
    bit                 fixed_hit;
    afbd_pkg::result_t  fixed_res;
  } script_row_t;

  // one random phase: register setting, length and idling
  typedef struct {
    logic [15:0] thr;
    logic [7:0]  cnt;
    int          words;
    int          send_gap;
    int          recv_gap;
    bit          squeeze;
  } phase_t;

  phase_t phases [6] = '{
    '{16'd0,     8'd0,   60,  9,  70, 1'b0},
    '{16'd4000,  8'd3,   120, 9,  70, 1'b1},
    '{16'd65535, 8'd1,   40,  70, 9,  1'b0},
    '{16'd12000, 8'd255, 80,  70, 9,  1'b0},
    '{16'd30000, 8'd7,   110, 0,  0,  1'b0},
    '{16'd1000,  8'd2,   100, 0,  0,  1'b0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  afbd_pkg::in_word_t stim;
  logic signed [17:0] left_o;
  logic signed [17:0] top_o;
  logic [16:0]        box_width_o;
  logic [16:0]        box_height_o;
  logic [7:0]         label_o;
  logic [15:0]        probability_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // side information travelling with the offered word
  logic               row_fixed;
  logic               row_fixed_hit;
  afbd_pkg::result_t  row_fixed_res;

  int unsigned        send_gap_pct = 9;
  int unsigned        recv_gap_pct = 70;
  int unsigned        hold_token   = 0;
  int unsigned        hold_seen    = 0;
  int unsigned        hold_left    = 0;
  int unsigned        cycle_count  = 0;
  int                 mismatches   = 0;

  // predictor state
  longint unsigned    pow2_lut [LUT_SIZE];
  logic [15:0]        thr_reg;
  logic [7:0]         cnt_reg;
  logic [7:0]         anchor_pos;
  afbd_pkg::result_t  held_box;
  logic [15:0]        held_obj;
  afbd_pkg::result_t  pending_boxes [$];

  anchor_free_box_decode_unit #(
    .EXP_TABLE_SIZE(LUT_SIZE)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .offset_x_i   (stim.offset_x),
    .offset_y_i   (stim.offset_y),
    .log_width_i  (stim.log_width),
    .log_height_i (stim.log_height),
    .objectness_i (stim.objectness),
    .grid_x_i     (stim.grid_x),
    .grid_y_i     (stim.grid_y),
    .stride_i     (stim.stride),
    .class_score_i(stim.class_score),
    .empty        (empty),
    .pop          (pop),
    .left_o       (left_o),
    .top_o        (top_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o),
    .label_o      (label_o),
    .probability_o(probability_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // 2^(k/256) in Q.30 from a truncating exp series
  function automatic void fill_pow2_lut();
    longint unsigned arg;
    longint unsigned term;
    longint unsigned acc;
    for (int k = 0; k < LUT_SIZE; k++) begin
      arg  = (64'(k) * LN2_FIX + LUT_SIZE / 2) / LUT_SIZE;
      term = 64'd1 << 30;
      acc  = term;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * arg) >> 30) / 64'(n);
        acc  = acc + term;
      end
      pow2_lut[k] = acc;
    end
  endfunction

  // centre in Q.4 pixels, rounded half up
  function automatic longint center_q4(input logic signed [15:0] off, input logic [7:0] grid,
                                       input logic [7:0] strd);
    longint c;
    c = (longint'(off) + longint'(grid) * 1024) * longint'(strd);
    return (c + 32) >>> 6;
  endfunction

  // exp(log size) * stride in Q.4 pixels, saturated
  function automatic logic [16:0] size_q4(input logic signed [15:0] lg, input logic [7:0] strd);
    longint          y;
    longint          n;
    longint          sh;
    longint unsigned v;
    int unsigned     k;
    y = longint'(lg) * LOG2E_FIX;
    n = y >>> 26;
    k = int'((y & 64'h3FF_FFFF) >> (26 - LUT_BITS));
    v = pow2_lut[k] * 64'(strd);
    if (v == 0) return 17'd0;
    sh = n - 26;
    if (sh >= 0) return 17'(SIZE_SAT);
    if (sh < -60) return 17'd0;
    v = (v + (64'd1 << (-sh - 1))) >> (-sh);
    return (v > SIZE_SAT) ? 17'(SIZE_SAT) : 17'(v);
  endfunction

  // corner = centre - half size, clamped to 18 bits
  function automatic logic signed [17:0] corner_q4(input longint ctr, input logic [16:0] sz);
    longint p;
    p = ctr - longint'(sz >> 1);
    if (p > CORNER_HI) p = CORNER_HI;
    else if (p < CORNER_LO) p = CORNER_LO;
    return 18'(p);
  endfunction

  // advance the class counter for one word and work out its detection, if any
  function automatic bit predict_box(input afbd_pkg::in_word_t w,
                                     output afbd_pkg::result_t r);
    int unsigned     span;
    longint unsigned prob;
    span = (cnt_reg == 0) ? 1 : cnt_reg;
    r = '0;
    r.label = anchor_pos;
    if (anchor_pos == 0) begin
      held_box.box_width  = size_q4(w.log_width, w.stride);
      held_box.box_height = size_q4(w.log_height, w.stride);
      held_box.left = corner_q4(center_q4(w.offset_x, w.grid_x, w.stride), held_box.box_width);
      held_box.top  = corner_q4(center_q4(w.offset_y, w.grid_y, w.stride), held_box.box_height);
      held_obj = w.objectness;
    end
    anchor_pos = (int'(anchor_pos) + 1 >= span) ? 8'd0 : anchor_pos + 8'd1;
    prob = (64'(held_obj) * 64'(w.class_score) + 64'd32768) >> 16;
    if (prob <= thr_reg) return 1'b0;
    r.left        = held_box.left;
    r.top         = held_box.top;
    r.box_width   = held_box.box_width;
    r.box_height  = held_box.box_height;
    r.probability = prob[15:0];
    return 1'b1;
  endfunction

  function automatic afbd_pkg::in_word_t mk_word(input int ox, input int oy, input int lw,
                                                 input int lh, input int obj, input int gx,
                                                 input int gy, input int st, input int sc);
    afbd_pkg::in_word_t w;
    w.offset_x    = 16'(ox);
    w.offset_y    = 16'(oy);
    w.log_width   = 16'(lw);
    w.log_height  = 16'(lh);
    w.objectness  = 16'(obj);
    w.grid_x      = 8'(gx);
    w.grid_y      = 8'(gy);
    w.stride      = 8'(st);
    w.class_score = 16'(sc);
    return w;
  endfunction

  function automatic afbd_pkg::result_t mk_res(input int l, input int t, input int bw,
                                               input int bh, input int lab, input int p);
    afbd_pkg::result_t r;
    r.left        = 18'(l);
    r.top         = 18'(t);
    r.box_width   = 17'(bw);
    r.box_height  = 17'(bh);
    r.label       = 8'(lab);
    r.probability = 16'(p);
    return r;
  endfunction

  // mostly plausible features, some raw noise
  function automatic afbd_pkg::in_word_t rand_word();
    afbd_pkg::in_word_t w;
    w.offset_x    = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4096)) - 16'd2048;
    w.offset_y    = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4096)) - 16'd2048;
    w.log_width   = ($urandom_range(7) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(6144)) - 16'd3072;
    w.log_height  = ($urandom_range(7) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(6144)) - 16'd3072;
    w.objectness  = ($urandom_range(3) != 0) ? 16'($urandom_range(65535, 30000))
                                             : 16'($urandom);
    w.grid_x      = 8'($urandom);
    w.grid_y      = 8'($urandom);
    w.stride      = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(128, 1));
    w.class_score = 16'($urandom);
    return w;
  endfunction

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // one config access, setup then access phase; psel is left high for back-to-back use
  task automatic cfg_access(input bit wr, input afbd_pkg::cfg_reg_e idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  // check the held value, write the new one and read it back
  task automatic program_one(input afbd_pkg::cfg_reg_e idx, input logic [31:0] held,
                             input logic [31:0] value);
    logic [31:0] rd;
    cfg_access(1'b0, idx, '0, rd);
    check_field(idx.name(), held, rd);
    cfg_access(1'b1, idx, value, rd);
    cfg_access(1'b0, idx, '0, rd);
    check_field(idx.name(), value, rd);
  endtask

  task automatic program_regs(input logic [15:0] thr, input logic [7:0] cnt);
    program_one(afbd_pkg::REG_SCORE_THRESHOLD, 32'(thr_reg), 32'(thr));
    thr_reg = thr;
    program_one(afbd_pkg::REG_CLASS_COUNT, 32'(cnt_reg), 32'(cnt));
    cnt_reg = cnt;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one word after a random gap and wait until it is taken
  task automatic offer(input script_row_t row);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    stim          <= row.word;
    row_fixed     <= row.fixed;
    row_fixed_hit <= row.fixed_hit;
    row_fixed_res <= row.fixed_res;
    do @(posedge clk_i); while (full);
  endtask

  // stop offering, drain all detections and let the back end go quiet
  task automatic settle();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_boxes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: random pop, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // scoreboard: check popped words, predict accepted words
  always @(posedge clk_i) begin
    afbd_pkg::result_t want;
    afbd_pkg::result_t calc;
    bit                hit;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_boxes.size() == 0) begin
          $display("%0t: expected no result word got label %0d probability %0d",
                   $time, label_o, probability_o);
          mismatches++;
        end else begin
          want = pending_boxes.pop_front();
          check_field("left", want.left, left_o);
          check_field("top", want.top, top_o);
          check_field("box_width", want.box_width, box_width_o);
          check_field("box_height", want.box_height, box_height_o);
          check_field("label", want.label, label_o);
          check_field("probability", want.probability, probability_o);
        end
      end
      if (push && !full) begin
        hit = predict_box(stim, calc);
        if (row_fixed) begin
          hit  = row_fixed_hit;
          calc = row_fixed_res;
        end
        if (hit) pending_boxes = {pending_boxes, calc};
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    script_row_t script [$];

    fill_pow2_lut();
    thr_reg    = afbd_pkg::SCORE_THRESHOLD_RESET;
    cnt_reg    = afbd_pkg::CLASS_COUNT_RESET;
    anchor_pos = '0;
    held_box   = '0;
    held_obj   = '0;

    rst_ni        <= 1'b0;
    push          <= 1'b0;
    stim          <= '0;
    row_fixed     <= 1'b0;
    row_fixed_hit <= 1'b0;
    row_fixed_res <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    // directed words at reset settings (threshold 16384, one class per anchor)
    // all zero features and no objectness: nothing emitted
    script.insert(script.size(), '{mk_word(0, 0, 0, 0, 0, 0, 0, 0, 65535), 1'b1, 1'b0, '0});
    // zero stride: empty box at the origin, top probability
    script.insert(script.size(), '{mk_word(0, 0, 0, 0, 65535, 0, 0, 0, 65535), 1'b1, 1'b1,
                                   mk_res(0, 0, 0, 0, 0, 65534)});
    // probability equal to the threshold: nothing emitted
    script.insert(script.size(), '{mk_word(0, 0, 0, 0, 32768, 0, 0, 0, 32768), 1'b1, 1'b0,
                                   '0});
    // one step above the threshold
    script.insert(script.size(), '{mk_word(0, 0, 0, 0, 32768, 0, 0, 0, 32770), 1'b1, 1'b1,
                                   mk_res(0, 0, 0, 0, 0, 16385)});
    // largest log size: size saturates
    script.insert(script.size(), '{mk_word(0, 0, 32767, 32767, 65535, 0, 0, 1, 65535),
                                   1'b1, 1'b1,
                                   mk_res(-65535, -65535, 131071, 131071, 0, 65534)});
    // far positive centre with vanishing size: corners clamp high
    script.insert(script.size(),
                  '{mk_word(32767, 32767, -32768, -32768, 65535, 255, 255, 128, 65535),
                    1'b1, 1'b1, mk_res(131071, 131071, 0, 0, 0, 65534)});
    // far negative centre with saturated size: corners clamp low
    script.insert(script.size(),
                  '{mk_word(-32768, -32768, 32767, 32767, 65535, 0, 0, 255, 65535),
                    1'b1, 1'b1, mk_res(-131072, -131072, 131071, 131071, 0, 65534)});
    // ordinary boxes, checked by the predictor
    script.insert(script.size(), '{mk_word(512, 512, 0, 0, 65535, 3, 4, 8, 60000),
                                   1'b0, 1'b0, '0});
    script.insert(script.size(), '{mk_word(-300, 700, -1024, 2048, 60000, 10, 20, 32, 50000),
                                   1'b0, 1'b0, '0});
    script.insert(script.size(), '{mk_word(1023, -1024, 4096, -4096, 50000, 79, 79, 16, 45000),
                                   1'b0, 1'b0, '0});
    script.insert(script.size(), '{mk_word(100, 100, 500, 500, 65535, 1, 1, 64, 0),
                                   1'b0, 1'b0, '0});
    script.insert(script.size(),
                  '{mk_word(-23131, 23130, 23130, -4660, 42405, 165, 90, 127, 65535),
                    1'b0, 1'b0, '0});
    script.insert(script.size(),
                  '{mk_word(21845, -21846, -3000, 3000, 65535, 170, 85, 2, 40000),
                    1'b0, 1'b0, '0});
    script.insert(script.size(), '{mk_word(0, 0, 7000, 7000, 65535, 128, 127, 128, 65535),
                                   1'b0, 1'b0, '0});
    script.insert(script.size(), '{mk_word(-1, -1, -1, -1, 65534, 254, 1, 1, 32767),
                                   1'b0, 1'b0, '0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(afbd_pkg::SCORE_THRESHOLD_RESET, afbd_pkg::CLASS_COUNT_RESET);
    foreach (script[i]) offer(script[i]);

    // random phases, register settings changed only while idle
    foreach (phases[p]) begin
      settle();
      program_regs(phases[p].thr, phases[p].cnt);
      send_gap_pct <= phases[p].send_gap;
      recv_gap_pct <= phases[p].recv_gap;
      if (phases[p].squeeze) hold_token <= hold_token + 1;
      repeat (phases[p].words) offer('{rand_word(), 1'b0, 1'b0, '0});
    end
    settle();

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
